### design/length_prefixed_packet_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, clocked on clk_i, off during reset.
`define LPPD_ASSERT_SAME(label, cond, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) \
    else $error("deframer check failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define LPPD_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error("deframer check failed");

`else

`define LPPD_ASSERT_SAME(label, cond, expr)
`define LPPD_ASSERT_NEXT(label, cond, expr)

`endif

`endif

### design/lppd_pkg.sv
// Shared constants for the length-prefixed packet deframer.
`timescale 1ns / 1ps

package lppd_pkg;

  // Header layout: 32-bit id then 32-bit length, MSB first.
  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned IdBytes     = HeaderBytes / 2;
  localparam int unsigned HdrCntW     = $clog2(HeaderBytes);

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdW     = 32;
  localparam int unsigned LenW    = 32;
  localparam int unsigned MaxLenW = 24;

  localparam logic [MaxLenW-1:0] MaxLenReset = 24'h01_0000;

endpackage

### design/lppd_if.sv
// Valid/ready channel interfaces: byte input, max-length config, result output.
`timescale 1ns / 1ps

interface lppd_byte_if;
  import lppd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lppd_cfg_if;
  import lppd_pkg::*;
  logic               valid;
  logic               ready;
  logic [MaxLenW-1:0] max_body_len;

  modport source (output valid, output max_body_len, input ready);
  modport sink   (input valid, input max_body_len, output ready);
endinterface

interface lppd_result_if;
  import lppd_pkg::*;
  logic             valid;
  logic             ready;
  logic [IdW-1:0]   packet_id;
  logic [LenW-1:0]  body_length;
  logic [ByteW-1:0] data_byte;
  logic             has_data;
  logic             last_of_packet;
  logic             oversize_error;

  modport source (output valid, output packet_id, output body_length, output data_byte,
                  output has_data, output last_of_packet, output oversize_error,
                  input ready);
  modport sink   (input valid, input packet_id, input body_length, input data_byte,
                  input has_data, input last_of_packet, input oversize_error,
                  output ready);
endinterface

### design/length_prefixed_packet_deframer.sv
// A result is registered and appears on out_o in the cycle after its byte is accepted.
// One byte per cycle unless out_o stalls; the single output register refills as it drains.
// Only the last header byte can give a result; bytes after an oversize error give none.
// Reset: phase returns to header, counters and shift registers clear, max length = 65536.
// The error phase is left only through rst_ni.
`timescale 1ns / 1ps

`include "length_prefixed_packet_deframer_macros.svh"

module length_prefixed_packet_deframer (
  input  logic          clk_i,
  input  logic          rst_ni,
  lppd_byte_if.sink     in_i,
  lppd_cfg_if.sink      cfg_i,
  lppd_result_if.source out_o
);
  import lppd_pkg::*;

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhBody   = 2'd1,
    PhError  = 2'd2
  } phase_e;

  localparam logic [HdrCntW-1:0] HdrLast = HdrCntW'(HeaderBytes - 1);
  localparam logic [HdrCntW-1:0] IdLimit = HdrCntW'(IdBytes);

  phase_e             phase_q, phase_d;
  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [IdW-1:0]     id_q, id_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [LenW-1:0]    rem_q, rem_d;
  logic [MaxLenW-1:0] max_len_q;

  logic             out_vld_q;
  logic [IdW-1:0]   out_id_q;
  logic [LenW-1:0]  out_len_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_has_q, out_last_q, out_err_q;

  logic             in_rdy;
  logic             accept;
  logic             res_vld;
  logic [ByteW-1:0] res_byte;
  logic             res_has, res_last, res_err;

  // Input is taken whenever the output register is empty or draining.
  assign in_rdy      = !out_vld_q || out_o.ready;
  assign in_i.ready  = in_rdy;
  assign accept      = in_i.valid && in_rdy;
  assign cfg_i.ready = 1'b1;

  // Per-byte parse step.
  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    id_d      = id_q;
    len_d     = len_q;
    rem_d     = rem_q;
    res_vld   = 1'b0;
    res_byte  = '0;
    res_has   = 1'b0;
    res_last  = 1'b0;
    res_err   = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PhHeader: begin
          if (hdr_cnt_q < IdLimit) begin
            id_d = {id_q[IdW-ByteW-1:0], in_i.in_byte};
          end else begin
            len_d = {len_q[LenW-ByteW-1:0], in_i.in_byte};
          end
          if (hdr_cnt_q != HdrLast) begin
            hdr_cnt_d = hdr_cnt_q + 1'b1;
          end else begin
            hdr_cnt_d = '0;
            if (len_d > {{(LenW-MaxLenW){1'b0}}, max_len_q}) begin
              phase_d = PhError;
              res_vld = 1'b1;
              res_err = 1'b1;
            end else if (len_d == '0) begin
              res_vld  = 1'b1;
              res_last = 1'b1;
            end else begin
              rem_d   = len_d;
              phase_d = PhBody;
            end
          end
        end
        PhBody: begin
          rem_d    = rem_q - 1'b1;
          res_vld  = 1'b1;
          res_byte = in_i.in_byte;
          res_has  = 1'b1;
          if (rem_d == '0) begin
            res_last = 1'b1;
            phase_d  = PhHeader;
          end
        end
        default: begin
          // error phase and unused code: byte is dropped
        end
      endcase
    end
  end

  // Parser state and config register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      hdr_cnt_q <= '0;
      id_q      <= '0;
      len_q     <= '0;
      rem_q     <= '0;
      max_len_q <= MaxLenReset;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      id_q      <= id_d;
      len_q     <= len_d;
      rem_q     <= rem_d;
      if (cfg_i.valid) begin
        max_len_q <= cfg_i.max_body_len;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_rdy) begin
      out_vld_q <= res_vld;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      out_id_q   <= id_d;
      out_len_q  <= len_d;
      out_byte_q <= res_byte;
      out_has_q  <= res_has;
      out_last_q <= res_last;
      out_err_q  <= res_err;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.packet_id      = out_id_q;
  assign out_o.body_length    = out_len_q;
  assign out_o.data_byte      = out_byte_q;
  assign out_o.has_data       = out_has_q;
  assign out_o.last_of_packet = out_last_q;
  assign out_o.oversize_error = out_err_q;

  // Error phase is sticky and produces nothing new.
  `LPPD_ASSERT_NEXT(a_err_sticky, phase_q == PhError, phase_q == PhError)
  `LPPD_ASSERT_NEXT(a_err_silent, phase_q == PhError && in_rdy, !out_vld_q)
  // Header byte counter only moves in header phase.
  `LPPD_ASSERT_SAME(a_cnt_phase, hdr_cnt_q != '0, phase_q == PhHeader)
  // Body phase always has bytes left.
  `LPPD_ASSERT_SAME(a_body_rem, phase_q == PhBody, rem_q != '0)

endmodule

### test/length_prefixed_packet_deframer_tb.sv
// Self-checking testbench for the length-prefixed packet deframer.
`timescale 1ns / 1ps

module length_prefixed_packet_deframer_tb;
  import lppd_pkg::*;

  // One result as it leaves the block
  typedef struct packed {
    logic [IdW-1:0]   packet_id;
    logic [LenW-1:0]  body_length;
    logic [ByteW-1:0] data_byte;
    logic             has_data;
    logic             last_of_packet;
    logic             oversize_error;
  } frag_t;

  // How a stimulus row's result is known
  typedef enum logic [1:0] {
    EXP_NONE,   // typed in: no result
    EXP_GIVEN,  // typed in: the result in the row
    EXP_MODEL   // worked out by the predictor
  } row_chk_e;

  typedef struct packed {
    logic [ByteW-1:0] b;
    row_chk_e         chk;
    frag_t            res;
  } stim_row_t;

  typedef enum logic [1:0] {PH_HDR, PH_BODY, PH_HALT} deframe_phase_e;

  localparam int StallLimit = 2000;
  localparam frag_t NoRes = '0;

  // Directed stream: empty packet with all-ones id, two-byte packet with zero id,
  // then a one-byte packet left to the predictor.
  localparam int DirRowCount = 27;
  localparam stim_row_t DirRows [DirRowCount] = '{
    '{8'hFF, EXP_NONE, NoRes}, '{8'hFF, EXP_NONE, NoRes},
    '{8'hFF, EXP_NONE, NoRes}, '{8'hFF, EXP_NONE, NoRes},
    '{8'h00, EXP_NONE, NoRes}, '{8'h00, EXP_NONE, NoRes},
    '{8'h00, EXP_NONE, NoRes},
    '{8'h00, EXP_GIVEN, '{32'hFFFF_FFFF, 32'h0, 8'h00, 1'b0, 1'b1, 1'b0}},
    '{8'h00, EXP_NONE, NoRes}, '{8'h00, EXP_NONE, NoRes},
    '{8'h00, EXP_NONE, NoRes}, '{8'h00, EXP_NONE, NoRes},
    '{8'h00, EXP_NONE, NoRes}, '{8'h00, EXP_NONE, NoRes},
    '{8'h00, EXP_NONE, NoRes}, '{8'h02, EXP_NONE, NoRes},
    '{8'hFF, EXP_GIVEN, '{32'h0, 32'h2, 8'hFF, 1'b1, 1'b0, 1'b0}},
    '{8'h00, EXP_GIVEN, '{32'h0, 32'h2, 8'h00, 1'b1, 1'b1, 1'b0}},
    '{8'h5A, EXP_MODEL, NoRes}, '{8'hA5, EXP_MODEL, NoRes},
    '{8'hC3, EXP_MODEL, NoRes}, '{8'h3C, EXP_MODEL, NoRes},
    '{8'h00, EXP_MODEL, NoRes}, '{8'h00, EXP_MODEL, NoRes},
    '{8'h00, EXP_MODEL, NoRes}, '{8'h01, EXP_MODEL, NoRes},
    '{8'h81, EXP_MODEL, NoRes}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  lppd_byte_if   in_if ();
  lppd_cfg_if    cfg_if ();
  lppd_result_if res_if ();

  length_prefixed_packet_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (res_if)
  );

  // Expected results, oldest first
  frag_t       frag_q[$];
  int unsigned mismatches = 0;
  int unsigned n_bytes = 0, n_data = 0, n_empty = 0, n_oversize = 0, n_writes = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned res_stall = 0;
  bit          calm = 1'b0;

  // Row info for the byte currently offered
  row_chk_e drv_chk = EXP_MODEL;
  frag_t    drv_given = '0;

  // Predictor state
  deframe_phase_e      pr_phase = PH_HDR;
  logic [HdrCntW-1:0]  pr_hdr_cnt = '0;
  logic [IdW-1:0]      pr_id = '0;
  logic [LenW-1:0]     pr_len = '0;
  logic [LenW-1:0]     pr_left = '0;
  logic [MaxLenW-1:0]  pr_max = MaxLenReset;

  // Append one expected result at the tail of the queue
  function automatic void queue_expected(input frag_t f);
    frag_q = {frag_q, f};
  endfunction

  // Advance the predictor by one byte; returns 1 when a result is due
  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output frag_t r);
    r = '0;
    case (pr_phase)
      PH_HDR: begin
        if (pr_hdr_cnt < IdBytes) pr_id = {pr_id[IdW-9:0], b};
        else pr_len = {pr_len[LenW-9:0], b};
        if (pr_hdr_cnt < HeaderBytes - 1) begin
          pr_hdr_cnt = pr_hdr_cnt + 1'b1;
          return 1'b0;
        end
        pr_hdr_cnt = '0;
        // length checked against the limit held at the last header byte
        if (pr_len > {8'd0, pr_max}) begin
          pr_phase = PH_HALT;
          r = '{pr_id, pr_len, 8'h00, 1'b0, 1'b0, 1'b1};
          return 1'b1;
        end
        if (pr_len == 0) begin
          r = '{pr_id, pr_len, 8'h00, 1'b0, 1'b1, 1'b0};
          return 1'b1;
        end
        pr_left = pr_len;
        pr_phase = PH_BODY;
        return 1'b0;
      end
      PH_BODY: begin
        pr_left = pr_left - 1'b1;
        r = '{pr_id, pr_len, b, 1'b1, (pr_left == 0), 1'b0};
        if (pr_left == 0) pr_phase = PH_HDR;
        return 1'b1;
      end
      default: return 1'b0;  // halted after an oversize header
    endcase
  endfunction

  // Body length drawn mostly short, now and then long, never over the limit
  function automatic logic [LenW-1:0] pick_len(input logic [MaxLenW-1:0] lim);
    int unsigned r, cap;
    r = $urandom_range(0, 39);
    if (lim == 0 || r < 8) return '0;
    if (r < 30) cap = 12;
    else if (r < 39) cap = 96;
    else cap = 300;
    if (cap > lim) cap = 32'(lim);
    return $urandom_range(1, cap);
  endfunction

  // Offer one byte, at times with a random gap first; returns at the falling edge after acceptance
  task automatic push_byte(input logic [ByteW-1:0] b);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_if.in_byte = b;
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_header(input logic [63:0] hdr, input int first, input int last);
    for (int i = first; i <= last; i++) push_byte(hdr[63-8*i -: 8]);
  endtask

  task automatic send_packet(input logic [IdW-1:0] id, input logic [LenW-1:0] len);
    if (calm) idle_pct = 0;
    else case ($urandom_range(0, 2))
      0: idle_pct = 0;
      1: idle_pct = 10;
      default: idle_pct = 35;
    endcase
    send_header({id, len}, 0, HeaderBytes - 1);
    for (int unsigned i = 0; i < len; i++) push_byte(ByteW'($urandom_range(0, 255)));
  endtask

  // Hold the stream until every result is in, let the block settle, then write the limit
  task automatic set_max_len(input logic [MaxLenW-1:0] v);
    in_if.valid = 1'b0;
    while (frag_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_if.max_body_len = v;
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Result side back-pressure
  always @(negedge clk_i) begin
    if (res_stall != 0) begin
      res_if.ready = 1'b0;
      res_stall--;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      res_if.ready = 1'b0;
      res_stall = $urandom_range(0, 14);
    end else begin
      res_if.ready = 1'b1;
    end
  end

  // Check results, track writes, predict from accepted bytes, watch for a hang
  always @(posedge clk_i) begin : monitor
    frag_t got, want, pred;
    bit    busy;
    busy = 1'b0;
    if (!rst_ni) begin
      pr_phase = PH_HDR;
      pr_hdr_cnt = '0;
      pr_id = '0;
      pr_len = '0;
      pr_left = '0;
      pr_max = MaxLenReset;
    end else begin
      if (res_if.valid && res_if.ready) begin
        busy = 1'b1;
        got = '{res_if.packet_id, res_if.body_length, res_if.data_byte,
                res_if.has_data, res_if.last_of_packet, res_if.oversize_error};
        if (frag_q.size() == 0) begin
          $error("unexpected result: packet_id %h data_byte %h", got.packet_id, got.data_byte);
          mismatches++;
        end else begin
          want = frag_q.pop_front();
          if (got.packet_id !== want.packet_id) begin
            $error("packet_id: expected %h, got %h", want.packet_id, got.packet_id);
            mismatches++;
          end
          if (got.body_length !== want.body_length) begin
            $error("body_length: expected %h, got %h", want.body_length, got.body_length);
            mismatches++;
          end
          if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected %h, got %h", want.data_byte, got.data_byte);
            mismatches++;
          end
          if (got.has_data !== want.has_data) begin
            $error("has_data: expected %b, got %b", want.has_data, got.has_data);
            mismatches++;
          end
          if (got.last_of_packet !== want.last_of_packet) begin
            $error("last_of_packet: expected %b, got %b", want.last_of_packet, got.last_of_packet);
            mismatches++;
          end
          if (got.oversize_error !== want.oversize_error) begin
            $error("oversize_error: expected %b, got %b", want.oversize_error, got.oversize_error);
            mismatches++;
          end
          if (want.oversize_error) n_oversize++;
          else if (want.has_data) n_data++;
          else n_empty++;
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        busy = 1'b1;
        pr_max = cfg_if.max_body_len;
        n_writes++;
      end
      if (in_if.valid && in_if.ready) begin
        busy = 1'b1;
        n_bytes++;
        if (deframe_byte(in_if.in_byte, pred) && drv_chk == EXP_MODEL) queue_expected(pred);
        if (drv_chk == EXP_GIVEN) queue_expected(drv_given);
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0]        hdr;
    logic [MaxLenW-1:0] lim;
    int unsigned        stop;

    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.max_body_len = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed stream under the reset limit
    idle_pct = 20;
    foreach (DirRows[i]) begin
      drv_chk = DirRows[i].chk;
      drv_given = DirRows[i].res;
      push_byte(DirRows[i].b);
    end
    drv_chk = EXP_MODEL;

    // Widest limit, random packets
    set_max_len('1);
    while (n_bytes < 550) send_packet($urandom, pick_len('1));

    // Limit rewritten in the middle of a header; length equals the new limit
    hdr = {32'($urandom), 32'd12};
    send_header(hdr, 0, 4);
    set_max_len(24'd12);
    send_header(hdr, 5, HeaderBytes - 1);
    repeat (12) push_byte(ByteW'($urandom_range(0, 255)));

    // Zero limit: only empty packets pass
    set_max_len('0);
    repeat (15) send_packet($urandom, '0);

    // Small limit, lengths often right at it
    lim = MaxLenW'($urandom_range(1, 12));
    set_max_len(lim);
    stop = n_bytes + 150;
    while (n_bytes < stop) send_packet($urandom, ($urandom_range(0, 2) == 0) ? lim : pick_len(lim));

    // Mid-range limit, idling dropped halfway
    lim = MaxLenW'($urandom_range(97, 16777214));
    set_max_len(lim);
    stop = n_bytes + 120;
    while (n_bytes < stop) send_packet($urandom, pick_len(lim));
    calm = 1'b1;
    stop = n_bytes + 120;
    while (n_bytes < stop) send_packet($urandom, pick_len(lim));

    // One past the widest limit: error, then every later byte is dropped
    set_max_len('1);
    idle_pct = 0;
    hdr = {32'($urandom), 32'h0100_0000};
    send_header(hdr, 0, HeaderBytes - 1);
    repeat (24) push_byte(ByteW'($urandom_range(0, 255)));
    in_if.valid = 1'b0;

    while (frag_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Deframed %0d bytes into %0d body bytes, %0d empty packets, %0d oversize errors.",
             n_bytes, n_data, n_empty, n_oversize);
    $display("Limit written %0d times, 0 and the full 24-bit value among them.", n_writes);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
